// File: rtl/t1bx_pkg.sv
// shared types, codes and constants for the T=1 block exchange control
package t1bx_pkg;

    // largest command transfer accepted on start
    localparam logic [16:0] MAX_COMMAND_BYTES = 17'd65535;

    // block kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_I    = 2'd0;
    localparam t_kind KIND_R    = 2'd1;
    localparam t_kind KIND_S    = 2'd2;
    localparam t_kind KIND_NONE = 2'd3;

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_CONTINUE      = 3'd0;
    localparam t_status ST_COMPLETE      = 3'd1;
    localparam t_status ST_BAD_REQUEST   = 3'd2;
    localparam t_status ST_WRONG_ADDRESS = 3'd3;
    localparam t_status ST_RX_FAILED     = 3'd4;
    localparam t_status ST_NOT_BUSY      = 3'd5;

    // item commands
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_HEADER = 1'b1;

    // configuration register indexes
    localparam logic CFG_NODE_ADDRESS    = 1'b0;
    localparam logic CFG_CARD_FIELD_SIZE = 1'b1;

    // protocol control byte bits
    localparam logic [7:0] PCB_I_SEQ      = 8'h40;
    localparam logic [7:0] PCB_I_MORE     = 8'h20;
    localparam logic [7:0] PCB_R_SEQ      = 8'h10;
    localparam logic [7:0] PCB_NOT_I      = 8'h80;
    localparam logic [7:0] PCB_S_FLAG     = 8'h40;
    localparam logic [7:0] PCB_S_RESPONSE = 8'h20;

    localparam logic [7:0] FIELD_SIZE_RESET = 8'd32;

    // one input word
    typedef struct packed {
        logic        cmd;
        logic [15:0] command_length;
        logic [15:0] response_capacity;
        logic [7:0]  rx_address;
        logic [7:0]  rx_control;
        logic [7:0]  rx_length;
        logic        rx_frame_ok;
    } t_item;

    // one result word
    typedef struct packed {
        t_kind       tx_kind;
        logic [7:0]  tx_control;
        logic [15:0] tx_offset;
        logic [7:0]  tx_length;
        logic [15:0] copy_offset;
        logic [7:0]  copy_length;
        logic        overflow;
        t_status     status;
        logic [15:0] response_total;
    } t_result;

    // protocol state kept across words and transfers
    typedef struct packed {
        logic        host_seq;
        logic        card_seq;
        logic        busy;
        logic [15:0] send_pos;
        logic [15:0] resp_pos;
        logic [7:0]  last_i_len;
        t_kind       pending_kind;
        logic [15:0] total_len;
        logic [15:0] capacity;
    } t_state;

endpackage

// File: rtl/t1bx_step.sv
// next block decision and state update for one word
module t1bx_step import t1bx_pkg::*; (
    input  t_state      i_state,
    input  t_item       i_item,
    input  logic [7:0]  i_node_address,
    input  logic [7:0]  i_card_field_size,
    output t_state      o_state,
    output t_result     o_result
);

    logic [7:0]  field;
    logic [16:0] adv_sum;
    logic [15:0] adv_pos;
    logic        is_start;
    logic        ack_adv;
    logic [15:0] ib_pos;
    logic [15:0] ib_total;
    logic        ib_seq;
    logic [16:0] ib_sum;
    logic        ib_more;
    logic [15:0] ib_rest;
    logic [7:0]  ib_len;
    logic [7:0]  ib_ctl;
    logic [15:0] room;
    logic        clip;
    logic [7:0]  copy_n;
    logic        bad_req;
    logic [7:0]  ack_ctl;

    // field size clamped to 1..254
    always_comb begin
        field = i_card_field_size;
        if (field == 8'd0) begin
            field = 8'd1;
        end else if (field == 8'd255) begin
            field = 8'd254;
        end
    end

    // acknowledged position, saturating at the transfer length
    assign adv_sum = {1'b0, i_state.send_pos} + {9'd0, i_state.last_i_len};
    assign adv_pos = (adv_sum > {1'b0, i_state.total_len}) ? i_state.total_len : adv_sum[15:0];

    // R-block from the card acknowledges our last I-block
    assign is_start = (i_item.cmd == CMD_START);
    assign ack_adv  = ((i_item.rx_control & PCB_R_SEQ) != 8'd0) != i_state.host_seq;

    // next I-block, built from the position it will be sent at
    assign ib_pos   = is_start ? 16'd0 : (ack_adv ? adv_pos : i_state.send_pos);
    assign ib_total = is_start ? i_item.command_length : i_state.total_len;
    assign ib_seq   = (!is_start && ack_adv) ? ~i_state.host_seq : i_state.host_seq;
    assign ib_sum   = {1'b0, ib_pos} + {9'd0, field};
    assign ib_more  = ib_sum < {1'b0, ib_total};
    assign ib_rest  = ib_total - ib_pos;
    assign ib_len   = ib_more ? field : ib_rest[7:0];
    assign ib_ctl   = (ib_seq ? PCB_I_SEQ : 8'd0) | (ib_more ? PCB_I_MORE : 8'd0);

    // room left in the response buffer and the clamped copy length
    assign room   = (i_state.capacity > i_state.resp_pos) ?
                    (i_state.capacity - i_state.resp_pos) : 16'd0;
    assign clip   = {8'd0, i_item.rx_length} > room;
    assign copy_n = clip ? room[7:0] : i_item.rx_length;

    assign bad_req = (i_item.response_capacity < 16'd2) || (i_item.command_length < 16'd4)
                     || ({1'b0, i_item.command_length} > MAX_COMMAND_BYTES);

    // R-block control byte, card sequence after the toggle on accepted data
    assign ack_ctl = PCB_NOT_I | ((~i_state.card_seq) ? PCB_R_SEQ : 8'd0);

    // decision
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.tx_kind = KIND_NONE;
        o_result.status  = ST_CONTINUE;
        if (is_start) begin
            if (bad_req) begin
                o_state.busy    = 1'b0;
                o_result.status = ST_BAD_REQUEST;
            end else begin
                o_state.busy         = 1'b1;
                o_state.send_pos     = 16'd0;
                o_state.resp_pos     = 16'd0;
                o_state.total_len    = i_item.command_length;
                o_state.capacity     = i_item.response_capacity;
                o_state.last_i_len   = ib_len;
                o_state.pending_kind = KIND_I;
                o_result.tx_kind     = KIND_I;
                o_result.tx_control  = ib_ctl;
                o_result.tx_offset   = ib_pos;
                o_result.tx_length   = ib_len;
            end
        end else if (!i_state.busy) begin
            o_result.status = ST_NOT_BUSY;
        end else if (!i_item.rx_frame_ok) begin
            o_state.busy    = 1'b0;
            o_result.status = ST_RX_FAILED;
        end else if (i_item.rx_address != i_node_address) begin
            o_state.busy    = 1'b0;
            o_result.status = ST_WRONG_ADDRESS;
        end else if ((i_item.rx_control & PCB_NOT_I) != 8'd0) begin
            if ((i_item.rx_control & PCB_S_FLAG) != 8'd0) begin
                // supervisory request echoed as response
                o_state.pending_kind = KIND_S;
                o_result.tx_kind     = KIND_S;
                o_result.tx_control  = i_item.rx_control | PCB_S_RESPONSE;
                o_result.tx_length   = i_item.rx_length;
            end else begin
                // R-block: resend or move on
                if (ack_adv) begin
                    o_state.send_pos = adv_pos;
                    o_state.host_seq = ~i_state.host_seq;
                end
                o_state.last_i_len   = ib_len;
                o_state.pending_kind = KIND_I;
                o_result.tx_kind     = KIND_I;
                o_result.tx_control  = ib_ctl;
                o_result.tx_offset   = ib_pos;
                o_result.tx_length   = ib_len;
            end
        end else if (((i_item.rx_control & PCB_I_SEQ) != 8'd0) == i_state.card_seq) begin
            // new card I-block: store data and acknowledge
            o_state.send_pos     = adv_pos;
            o_state.card_seq     = ~i_state.card_seq;
            o_result.overflow    = clip;
            o_result.copy_offset = i_state.resp_pos;
            o_result.copy_length = copy_n;
            o_state.resp_pos     = i_state.resp_pos + {8'd0, copy_n};
            if ((i_item.rx_control & PCB_I_MORE) == 8'd0) begin
                o_state.host_seq   = ~i_state.host_seq;
                o_state.busy       = 1'b0;
                o_state.last_i_len = 8'd0;
                o_result.status    = ST_COMPLETE;
            end else begin
                o_state.last_i_len   = 8'd0;
                o_state.pending_kind = KIND_R;
                o_result.tx_kind     = KIND_R;
                o_result.tx_control  = ack_ctl;
            end
        end else begin
            // repeated card I-block: ask again, no copy
            o_state.last_i_len   = 8'd0;
            o_state.pending_kind = KIND_R;
            o_result.tx_kind     = KIND_R;
            o_result.tx_control  = PCB_NOT_I | (i_state.card_seq ? PCB_R_SEQ : 8'd0);
        end
        o_result.response_total = o_state.resp_pos;
    end

endmodule

// File: rtl/t1_block_exchange_control.sv
// top level of the T=1 block exchange control
//
// channel   direction  handshake                  contents
// item      in         i_valid / o_ready          cmd, lengths, received header
// result    out        o_valid / i_ready          next block, copy window, status
// config    in         i_cfg_valid / o_cfg_ready  register index and data
//
// every word is held in the input register, then passes through the decision
// logic into the result register; one word is taken each cycle the input
// register is empty or passing its word on, so words go back to back
// reset (synchronous, active low) clears state, valid flags and config registers to defaults
// a stalled result holds while the input register still takes one word
// configuration writes are taken in any cycle, one per cycle
module t1_block_exchange_control import t1bx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [15:0] i_command_length,
    input  logic [15:0] i_response_capacity,
    input  logic [7:0]  i_rx_address,
    input  logic [7:0]  i_rx_control,
    input  logic [7:0]  i_rx_length,
    input  logic        i_rx_frame_ok,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_tx_kind,
    output logic [7:0]  o_tx_control,
    output logic [15:0] o_tx_offset,
    output logic [7:0]  o_tx_length,
    output logic [15:0] o_copy_offset,
    output logic [7:0]  o_copy_length,
    output logic        o_overflow,
    output logic [2:0]  o_status,
    output logic [15:0] o_response_total,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_state  r_state;
    logic [7:0] r_node_address;
    logic [7:0] r_card_field_size;

    t_state  n_state;
    t_result n_result;
    t_item   in_word;
    logic    advance;
    logic    accept;

    // pipeline handshakes
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign accept  = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign in_word = '{cmd: i_cmd, command_length: i_command_length,
                       response_capacity: i_response_capacity,
                       rx_address: i_rx_address, rx_control: i_rx_control,
                       rx_length: i_rx_length, rx_frame_ok: i_rx_frame_ok};

    // decision logic
    t1bx_step u_step (
        .i_state           (r_state),
        .i_item            (r_in),
        .i_node_address    (r_node_address),
        .i_card_field_size (r_card_field_size),
        .o_state           (n_state),
        .o_result          (n_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !advance);
        end
        if (accept) begin
            r_in <= in_word;
        end
    end

    // result register and protocol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{host_seq: 1'b0, card_seq: 1'b0, busy: 1'b0,
                             send_pos: 16'd0, resp_pos: 16'd0, last_i_len: 8'd0,
                             pending_kind: KIND_I, total_len: 16'd0, capacity: 16'd0};
        end else begin
            r_out_valid <= advance || (r_out_valid && !i_ready);
            if (advance) begin
                r_state <= n_state;
            end
        end
        if (advance) begin
            r_out <= n_result;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address    <= 8'd0;
            r_card_field_size <= FIELD_SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODE_ADDRESS:    r_node_address    <= i_cfg_data;
                CFG_CARD_FIELD_SIZE: r_card_field_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result ports
    assign o_valid          = r_out_valid;
    assign o_tx_kind        = r_out.tx_kind;
    assign o_tx_control     = r_out.tx_control;
    assign o_tx_offset      = r_out.tx_offset;
    assign o_tx_length      = r_out.tx_length;
    assign o_copy_offset    = r_out.copy_offset;
    assign o_copy_length    = r_out.copy_length;
    assign o_overflow       = r_out.overflow;
    assign o_status         = r_out.status;
    assign o_response_total = r_out.response_total;

    // send position never runs past the transfer length
    a_send_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.send_pos <= r_state.total_len)
        else $error("send position beyond transfer length");

    // any status other than continue sends no block
    a_stop_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_CONTINUE)) |-> (o_tx_kind == KIND_NONE))
        else $error("block sent with a terminal status");

    // a finished transfer leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_result.status != ST_CONTINUE)) |=> !r_state.busy)
        else $error("still busy after transfer ended");

    // an R-block never carries payload or offset
    a_r_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_tx_kind == KIND_R)) |->
            ((o_tx_length == 8'd0) && (o_tx_offset == 16'd0)))
        else $error("R-block with payload");

endmodule
